### rtl/kefp_pkg.sv
// ----------------------------------------------------------------------------
// kefp_pkg
// Shared constants, status codes and the controller/datapath command and
// status bundles of the key event frame parser.
// ----------------------------------------------------------------------------
package kefp_pkg;

  localparam int MAX_KEYS = 32;
  // key counter holds 0..MAX_KEYS, store index addresses 0..MAX_KEYS-1
  localparam int KEY_W = $clog2(MAX_KEYS + 1);
  localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  localparam logic [7:0]  HDR_BYTE   = 8'hFD;
  localparam logic [15:0] SUM_SEED   = 16'hFDFD;
  localparam logic [3:0]  MIN_BUFFER = 4'd11;
  localparam logic [7:0]  MAX_KEYS_B = 8'(MAX_KEYS);

  // ST_KEY_EVENT also stands for "no error" in the held-error register
  typedef enum logic [2:0] {
    ST_KEY_EVENT = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NO_HEADER = 3'd2,
    ST_TOO_MANY  = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_BAD_SUM   = 3'd5,
    ST_DISABLED  = 3'd6
  } status_t;

  typedef struct packed {
    logic    seed;
    logic    load_count;
    logic    sum_feed;
    logic    sum_flush;
    logic    rec_byte;
    logic    crc_hi_ld;
    logic    err_ld;
    status_t err_code;
    logic    drain_start;
    logic    drain_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic hdr_byte;
    logic count_big;
    logic count_zero;
    logic rec_last;
    logic crc_ok;
    logic keys_zero;
    logic drain_last;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/kefp_byte_if.sv
// ----------------------------------------------------------------------------
// kefp_byte_if
// Input channel: one received buffer byte per item, with end-of-buffer flag.
// ----------------------------------------------------------------------------
interface kefp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

### rtl/kefp_result_if.sv
// ----------------------------------------------------------------------------
// kefp_result_if
// Result channel: a decoded key event record or an error status.
// ----------------------------------------------------------------------------
interface kefp_result_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic        [15:0] event_type;
  logic        [15:0] event_code;
  logic signed [31:0] event_value;
  logic               last_result;

  modport source (output valid, output status, output event_type, output event_code,
                  output event_value, output last_result, input ready);
  modport sink   (input valid, input status, input event_type, input event_code,
                  input event_value, input last_result, output ready);
endinterface

### rtl/kefp_datapath.sv
// ----------------------------------------------------------------------------
// kefp_datapath
// Checksum accumulator, record assembly and store, key counters and the
// result register.
// ----------------------------------------------------------------------------
module kefp_datapath import kefp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [15:0]        out_type,
  output logic [15:0]        out_code,
  output logic signed [31:0] out_value,
  output logic               out_last
);

  logic [15:0]      running_sum;
  logic             hbp_valid;
  logic [7:0]       hbp_byte;
  logic [7:0]       crc_high;
  logic [KEY_W-1:0] keys_expected;
  logic [KEY_W-1:0] record_index;
  logic [KEY_W-1:0] drain_index;
  logic [2:0]       record_byte_index;
  logic [55:0]      record_shift;
  logic [63:0]      store [MAX_KEYS];
  logic [63:0]      rd_data;

  logic [15:0]      word_in;
  logic [16:0]      sum_wide;
  logic [15:0]      sum_add;
  logic [KEY_W-1:0] record_index_inc;
  logic [KEY_W-1:0] drain_index_inc;

  // odd trailing byte goes in as a high byte with zero low byte
  assign word_in  = hbp_valid ? {hbp_byte, rx_byte} : {rx_byte, 8'h00};
  assign sum_wide = {1'b0, running_sum} + {1'b0, word_in};
  assign sum_add  = sum_wide[15:0] + {15'd0, sum_wide[16]};

  assign record_index_inc = record_index + KEY_W'(1);
  assign drain_index_inc  = drain_index + KEY_W'(1);

  always_comb begin
    stat.hdr_byte   = (rx_byte == HDR_BYTE);
    stat.count_big  = (rx_byte > MAX_KEYS_B);
    stat.count_zero = (rx_byte == 8'd0);
    stat.rec_last   = (record_byte_index == 3'd7) && (record_index_inc == keys_expected);
    stat.crc_ok     = (~running_sum == {crc_high, rx_byte});
    stat.keys_zero  = (keys_expected == '0);
    stat.drain_last = (drain_index_inc == keys_expected);
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum       <= SUM_SEED;
      hbp_valid         <= 1'b0;
      record_index      <= '0;
      record_byte_index <= 3'd0;
      keys_expected     <= '0;
      drain_index       <= '0;
    end else begin
      if (cmd.seed) begin
        running_sum       <= SUM_SEED;
        hbp_valid         <= 1'b0;
        record_index      <= '0;
        record_byte_index <= 3'd0;
      end else begin
        if (cmd.sum_feed) begin
          if (hbp_valid || cmd.sum_flush) begin
            running_sum <= sum_add;
            hbp_valid   <= 1'b0;
          end else begin
            hbp_valid <= 1'b1;
          end
        end
        if (cmd.rec_byte) begin
          record_byte_index <= 3'(record_byte_index + 3'd1);
          if (record_byte_index == 3'd7) begin
            record_index <= record_index_inc;
          end
        end
      end
      if (cmd.load_count) begin
        keys_expected <= rx_byte[KEY_W-1:0];
      end
      if (cmd.drain_start) begin
        drain_index <= '0;
      end else if (cmd.drain_ld) begin
        drain_index <= drain_index_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_feed) begin
      hbp_byte <= rx_byte;
    end
    if (cmd.crc_hi_ld) begin
      crc_high <= rx_byte;
    end
    if (cmd.rec_byte) begin
      record_shift <= {record_shift[47:0], rx_byte};
      if (record_byte_index == 3'd7) begin
        store[record_index[IDX_W-1:0]] <= {record_shift, rx_byte};
      end
    end
    rd_data <= store[drain_index[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.err_ld || cmd.drain_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_ld) begin
      out_status <= cmd.err_code;
      out_type   <= 16'd0;
      out_code   <= 16'd0;
      out_value  <= 32'sd0;
      out_last   <= 1'b1;
    end else if (cmd.drain_ld) begin
      out_status <= ST_KEY_EVENT;
      out_type   <= rd_data[63:48];
      out_code   <= rd_data[47:32];
      out_value  <= signed'(rd_data[31:0]);
      out_last   <= stat.drain_last;
    end
  end

endmodule

### rtl/kefp_ctrl.sv
// ----------------------------------------------------------------------------
// kefp_ctrl
// Frame state machine: header search, count, records, checksum, discard and
// record drain, plus per-buffer byte count and error bookkeeping.
// ----------------------------------------------------------------------------
module kefp_ctrl import kefp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data,
  input  logic     in_valid,
  input  logic     buffer_end,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_SEARCH0  = 9'b000000001,
    S_SEARCH1  = 9'b000000010,
    S_COUNT    = 9'b000000100,
    S_RECORDS  = 9'b000001000,
    S_CRC_HI   = 9'b000010000,
    S_CRC_LO   = 9'b000100000,
    S_DISCARD  = 9'b001000000,
    S_DRAIN_RD = 9'b010000000,
    S_DRAIN_LD = 9'b100000000
  } state_t;

  state_t     state, state_next;
  logic [3:0] byte_count, byte_count_next;
  status_t    error_held, error_held_next;
  logic       rejected, rejected_next;
  logic       parser_enable;

  logic       draining;
  logic       accept;
  logic       first;
  logic       full;
  logic       frame_done;
  logic       res_valid;
  status_t    res_code;
  status_t    err;
  status_t    held;
  logic       rej;
  logic [3:0] count_inc;
  state_t     ph;
  state_t     ph_n;

  assign draining = (state == S_DRAIN_RD) || (state == S_DRAIN_LD);
  assign in_ready = !draining && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd             = '0;
    state_next      = state;
    byte_count_next = byte_count;
    error_held_next = error_held;
    rejected_next   = rejected;
    first           = (byte_count == 4'd0);
    count_inc       = (byte_count < MIN_BUFFER) ? 4'(byte_count + 4'd1) : byte_count;
    full            = (count_inc == MIN_BUFFER);
    ph              = state;
    held            = error_held;
    rej             = rejected;
    if (first) begin
      ph   = parser_enable ? S_SEARCH0 : S_DISCARD;
      held = ST_KEY_EVENT;
      rej  = !parser_enable;
    end
    ph_n       = ph;
    err        = ST_KEY_EVENT;
    frame_done = 1'b0;
    res_valid  = 1'b0;
    res_code   = ST_KEY_EVENT;

    case (state)
      S_DRAIN_RD: begin
        state_next = S_DRAIN_LD;
      end
      S_DRAIN_LD: begin
        if (stat.out_free) begin
          cmd.drain_ld = 1'b1;
          state_next   = stat.drain_last ? S_SEARCH0 : S_DRAIN_RD;
        end
      end
      default: begin
        if (accept) begin
          if (first && !parser_enable) begin
            res_valid = 1'b1;
            res_code  = ST_DISABLED;
          end

          case (ph)
            S_SEARCH0: begin
              if (stat.hdr_byte) begin
                ph_n = S_SEARCH1;
              end
            end
            S_SEARCH1: begin
              if (stat.hdr_byte) begin
                ph_n     = S_COUNT;
                cmd.seed = 1'b1;
              end else begin
                ph_n = S_SEARCH0;
              end
            end
            S_COUNT: begin
              cmd.load_count = 1'b1;
              if (stat.count_big) begin
                err = ST_TOO_MANY;
              end else begin
                cmd.sum_feed = 1'b1;
                if (stat.count_zero) begin
                  cmd.sum_flush = 1'b1;
                  ph_n          = S_CRC_HI;
                end else begin
                  ph_n = S_RECORDS;
                end
              end
            end
            S_RECORDS: begin
              cmd.rec_byte = 1'b1;
              cmd.sum_feed = 1'b1;
              if (stat.rec_last) begin
                cmd.sum_flush = 1'b1;
                ph_n          = S_CRC_HI;
              end
            end
            S_CRC_HI: begin
              cmd.crc_hi_ld = 1'b1;
              ph_n          = S_CRC_LO;
            end
            S_CRC_LO: begin
              if (stat.crc_ok) begin
                frame_done = 1'b1;
                if (stat.keys_zero) begin
                  ph_n = S_SEARCH0;
                end else begin
                  ph_n            = S_DRAIN_RD;
                  cmd.drain_start = 1'b1;
                end
              end else begin
                err = ST_BAD_SUM;
              end
            end
            default: begin
            end
          endcase

          // buffer ran out mid-frame or while still hunting for a header
          if (err == ST_KEY_EVENT && buffer_end && !frame_done) begin
            if (ph_n == S_SEARCH0 || ph_n == S_SEARCH1) begin
              err = ST_NO_HEADER;
            end else if (ph_n != S_DISCARD) begin
              err = ST_TRUNCATED;
            end
          end

          // errors before the eleventh byte wait for it
          if (err != ST_KEY_EVENT) begin
            ph_n = S_DISCARD;
            if (full) begin
              res_valid = 1'b1;
              res_code  = err;
            end else begin
              held = err;
            end
          end else if (ph_n == S_DISCARD && held != ST_KEY_EVENT && full) begin
            res_valid = 1'b1;
            res_code  = held;
            held      = ST_KEY_EVENT;
          end

          if (buffer_end) begin
            if (!full && !rej) begin
              res_valid = 1'b1;
              res_code  = ST_SHORT;
            end
            byte_count_next = 4'd0;
            error_held_next = ST_KEY_EVENT;
            rejected_next   = 1'b0;
            if (ph_n != S_DRAIN_RD) begin
              ph_n = S_SEARCH0;
            end
          end else begin
            byte_count_next = count_inc;
            error_held_next = held;
            rejected_next   = rej;
          end

          cmd.err_ld   = res_valid;
          cmd.err_code = res_code;
          state_next   = ph_n;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SEARCH0;
      byte_count    <= 4'd0;
      error_held    <= ST_KEY_EVENT;
      rejected      <= 1'b0;
      parser_enable <= 1'b1;
    end else begin
      state      <= state_next;
      byte_count <= byte_count_next;
      error_held <= error_held_next;
      rejected   <= rejected_next;
      if (cfg_wr_en) begin
        parser_enable <= cfg_wr_data;
      end
    end
  end

endmodule

### rtl/key_event_frame_parser.sv
// Results: an error result enters the result register as the byte that
//   causes it is accepted, or with the buffer's eleventh byte if later;
//   a verified frame's records follow from the store via S_DRAIN_RD/LD.
// Throughput: one byte per cycle while the result register is free;
//   input is held off while records drain via the registered read port.
// Reset (rst, synchronous): header search, enable set; store not cleared.
// ----------------------------------------------------------------------------
// key_event_frame_parser
// Parses 0xFD 0xFD framed key event records from a byte stream and emits
// checksum-verified records or an error status per buffer.
// ----------------------------------------------------------------------------
module key_event_frame_parser import kefp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  kefp_byte_if.sink     in_ch,
  kefp_result_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  kefp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_ch.valid),
    .buffer_end  (in_ch.buffer_end),
    .in_ready    (in_ch.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  kefp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (in_ch.rx_byte),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_type   (out_ch.event_type),
    .out_code   (out_ch.event_code),
    .out_value  (out_ch.event_value),
    .out_last   (out_ch.last_result)
  );

endmodule

### rtl/kefp_checker.sv
// ----------------------------------------------------------------------------
// kefp_checker
// Port-level checks of the key event frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module kefp_checker import kefp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [15:0] event_type,
  input logic [15:0] event_code,
  input logic [31:0] event_value,
  input logic        last_result
);

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered straight after reset");

  // an error item carries no record and closes the byte's results
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_KEY_EVENT |->
      event_type == 16'd0 && event_code == 16'd0 && event_value == 32'd0 && last_result)
    else $error("error item with record fields or without last flag");

  // no byte is taken while a record burst is still going out
  a_burst_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_KEY_EVENT && !last_result |-> !(in_valid && in_ready))
    else $error("byte accepted in the middle of a record burst");

  a_err_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && status != ST_KEY_EVENT |-> $past(in_valid && in_ready))
    else $error("error item with no byte behind it");

endmodule

bind key_event_frame_parser kefp_checker u_kefp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .event_type  (out_ch.event_type),
  .event_code  (out_ch.event_code),
  .event_value (out_ch.event_value),
  .last_result (out_ch.last_result)
);

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for key_event_frame_parser: feeds receive buffers a
// byte at a time, framed key records with random content among noise, short,
// truncated and corrupted buffers, and compares every result item against a
// bit-level predictor of the parser. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb import kefp_pkg::*; ();

  localparam int LIMIT  = 3000;
  localparam int SETTLE = 2 * MAX_KEYS + 8;
  localparam int HOLD   = 300;

  typedef enum logic [2:0] {
    P_SEEK0, P_SEEK1, P_COUNT, P_RECORDS, P_CRC_HI, P_CRC_LO, P_DISCARD
  } parse_phase_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] ev_type;
    logic [15:0] ev_code;
    logic [31:0] ev_value;
    logic        last;
  } key_result_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buf_end;
    logic       typed;
    status_t    typed_status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  kefp_byte_if   byte_ch ();
  kefp_result_if result_ch ();

  key_event_frame_parser dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (byte_ch),
    .out_ch      (result_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic          parser_on;
  parse_phase_t  prs_phase;
  logic [7:0]    keys_due;
  logic [2:0]    rec_byte_no;
  logic [7:0]    rec_no;
  logic [15:0]   chk_sum;
  logic [8:0]    chk_pend;
  logic [7:0]    crc_hi_byte;
  logic [3:0]    buf_bytes;
  status_t       held_err;
  logic          buf_refused;
  logic [63:0]   rec_store [MAX_KEYS];

  key_result_t expected_events [$];
  logic [7:0]  buf_q [$];
  int          mismatches = 0;
  int          tx_burst = 0;
  int          rx_burst = 0;
  int          quiet_cycles = 0;
  bit          long_hold_req = 0;

  // short buffers, a count over the limit on a short buffer's end, then one
  // record of extreme fields with a valid checksum
  stim_row_t directed_rows [0:18] = '{
    '{8'h00, 1'b0, 1'b0, ST_KEY_EVENT},
    '{8'hFF, 1'b1, 1'b1, ST_SHORT},
    '{8'hFD, 1'b0, 1'b0, ST_KEY_EVENT},
    '{8'hFD, 1'b0, 1'b0, ST_KEY_EVENT},
    '{8'hFF, 1'b1, 1'b1, ST_SHORT},
    '{8'hFD, 1'b1, 1'b1, ST_SHORT},
    '{8'hFD, 1'b0, 1'b0, ST_KEY_EVENT},
    '{8'hFD, 1'b0, 1'b0, ST_KEY_EVENT},
    '{8'h01, 1'b0, 1'b0, ST_KEY_EVENT},
    '{8'h00, 1'b0, 1'b0, ST_KEY_EVENT},
    '{8'h00, 1'b0, 1'b0, ST_KEY_EVENT},
    '{8'hFF, 1'b0, 1'b0, ST_KEY_EVENT},
    '{8'hFF, 1'b0, 1'b0, ST_KEY_EVENT},
    '{8'h80, 1'b0, 1'b0, ST_KEY_EVENT},
    '{8'h00, 1'b0, 1'b0, ST_KEY_EVENT},
    '{8'h00, 1'b0, 1'b0, ST_KEY_EVENT},
    '{8'h00, 1'b0, 1'b0, ST_KEY_EVENT},
    '{8'h00, 1'b0, 1'b0, ST_KEY_EVENT},
    '{8'h82, 1'b1, 1'b0, ST_KEY_EVENT}
  };

  function automatic key_result_t error_result(input status_t st);
    return '{status: st, ev_type: 16'h0, ev_code: 16'h0, ev_value: 32'h0, last: 1'b1};
  endfunction

  function automatic void add_word(input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, chk_sum} + {1'b0, w};
    chk_sum = s[15:0] + {15'h0, s[16]};
  endfunction

  function automatic void sum_byte(input logic [7:0] b);
    if (chk_pend[8]) begin
      add_word({chk_pend[7:0], b});
      chk_pend = '0;
    end else begin
      chk_pend = {1'b1, b};
    end
  endfunction

  function automatic void sum_flush();
    if (chk_pend[8]) add_word({chk_pend[7:0], 8'h00});
    chk_pend = '0;
  endfunction

  task automatic reset_predictor();
    parser_on   = 1'b1;
    prs_phase   = P_SEEK0;
    keys_due    = '0;
    rec_byte_no = '0;
    rec_no      = '0;
    chk_sum     = SUM_SEED;
    chk_pend    = '0;
    crc_hi_byte = '0;
    buf_bytes   = '0;
    held_err    = ST_KEY_EVENT;
    buf_refused = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic e, output key_result_t res [$]);
    status_t     err;
    logic        done;
    logic [63:0] prev;
    res  = {};
    err  = ST_KEY_EVENT;
    done = 1'b0;
    if (buf_bytes == 0) begin
      held_err    = ST_KEY_EVENT;
      buf_refused = 1'b0;
      prs_phase   = P_SEEK0;
      if (!parser_on) begin
        prs_phase   = P_DISCARD;
        buf_refused = 1'b1;
        res         = '{error_result(ST_DISABLED)};
      end
    end
    if (buf_bytes < MIN_BUFFER) buf_bytes = buf_bytes + 4'd1;

    case (prs_phase)
      P_SEEK0: if (b == HDR_BYTE) prs_phase = P_SEEK1;
      P_SEEK1: begin
        if (b == HDR_BYTE) begin
          prs_phase   = P_COUNT;
          chk_sum     = SUM_SEED;
          chk_pend    = '0;
          rec_no      = '0;
          rec_byte_no = '0;
        end else begin
          prs_phase = P_SEEK0;
        end
      end
      P_COUNT: begin
        keys_due = b;
        if (b > MAX_KEYS_B) begin
          err = ST_TOO_MANY;
        end else begin
          sum_byte(b);
          if (b == 8'h00) begin
            sum_flush();
            prs_phase = P_CRC_HI;
          end else begin
            prs_phase = P_RECORDS;
          end
        end
      end
      P_RECORDS: begin
        if (rec_no < MAX_KEYS) begin
          prev = (rec_byte_no == 0) ? 64'h0 : rec_store[rec_no];
          rec_store[rec_no] = {prev[55:0], b};
        end
        sum_byte(b);
        rec_byte_no = rec_byte_no + 3'd1;
        if (rec_byte_no == 0) begin
          rec_no = rec_no + 8'd1;
          if (rec_no >= keys_due) begin
            sum_flush();
            prs_phase = P_CRC_HI;
          end
        end
      end
      P_CRC_HI: begin
        crc_hi_byte = b;
        prs_phase   = P_CRC_LO;
      end
      P_CRC_LO: begin
        if (~chk_sum == {crc_hi_byte, b}) begin
          res = {};
          for (int k = 0; k < keys_due && k < MAX_KEYS; k++)
            res.push_back('{status: ST_KEY_EVENT, ev_type: rec_store[k][63:48],
                            ev_code: rec_store[k][47:32], ev_value: rec_store[k][31:0],
                            last: 1'b0});
          if (res.size() > 0) res[res.size() - 1].last = 1'b1;
          prs_phase = P_SEEK0;
          done      = 1'b1;
        end else begin
          err = ST_BAD_SUM;
        end
      end
      default: ;
    endcase

    if (err == ST_KEY_EVENT && e && !done) begin
      if (prs_phase == P_SEEK0 || prs_phase == P_SEEK1)
        err = ST_NO_HEADER;
      else if (prs_phase >= P_COUNT && prs_phase <= P_CRC_LO)
        err = ST_TRUNCATED;
    end

    if (err != ST_KEY_EVENT) begin
      prs_phase = P_DISCARD;
      if (buf_bytes >= MIN_BUFFER) res = '{error_result(err)};
      else held_err = err;
    end else if (prs_phase == P_DISCARD && held_err != ST_KEY_EVENT &&
                 buf_bytes >= MIN_BUFFER) begin
      res      = '{error_result(held_err)};
      held_err = ST_KEY_EVENT;
    end

    if (e) begin
      if (buf_bytes < MIN_BUFFER && !buf_refused) res = '{error_result(ST_SHORT)};
      buf_bytes   = '0;
      prs_phase   = P_SEEK0;
      held_err    = ST_KEY_EVENT;
      buf_refused = 1'b0;
    end
  endtask

  // mostly an idle gap of random length, now and then a run of back-to-back items
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  task automatic send_item(input logic [7:0] b, input logic e, input logic typed,
                           input status_t st);
    int          gap;
    key_result_t res [$];
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.rx_byte    <= b;
    byte_ch.buffer_end <= e;
    do @(posedge clk); while (!byte_ch.ready);
    decode_byte(b, e, res);
    if (typed) expected_events.push_back(error_result(st));
    else foreach (res[i]) expected_events.push_back(res[i]);
    @(negedge clk);
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if (v == HDR_BYTE) v = 8'hFC;
    return v;
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'hFDFD;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'hFDFD_FDFD;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_frame(input int nkeys, input bit bad_sum);
    logic [7:0]  body [$];
    logic [15:0] sum, crc, w, t, c;
    logic [31:0] v;
    logic [16:0] acc;
    body.push_back(8'(nkeys));
    for (int k = 0; k < nkeys; k++) begin
      t = pick16();
      c = pick16();
      v = pick32();
      body.push_back(t[15:8]); body.push_back(t[7:0]);
      body.push_back(c[15:8]); body.push_back(c[7:0]);
      body.push_back(v[31:24]); body.push_back(v[23:16]);
      body.push_back(v[15:8]); body.push_back(v[7:0]);
    end
    sum = SUM_SEED;
    for (int i = 0; i < body.size(); i += 2) begin
      w   = {body[i], (i + 1 < body.size()) ? body[i + 1] : 8'h00};
      acc = {1'b0, sum} + {1'b0, w};
      sum = acc[15:0] + {15'h0, acc[16]};
    end
    crc = ~sum;
    if (bad_sum) crc = crc ^ (16'h1 << $urandom_range(0, 15));
    buf_q.push_back(HDR_BYTE);
    buf_q.push_back(HDR_BYTE);
    foreach (body[i]) buf_q.push_back(body[i]);
    buf_q.push_back(crc[15:8]);
    buf_q.push_back(crc[7:0]);
  endtask

  task automatic build_buffer();
    int kind, cut;
    buf_q = {};
    kind  = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 10))
        buf_q.push_back(($urandom_range(0, 2) == 0) ? HDR_BYTE : noise_byte());
    end else if (kind < 16) begin
      // noise with the odd 0xFD
      repeat ($urandom_range(11, 18))
        buf_q.push_back(($urandom_range(0, 5) == 0) ? HDR_BYTE : noise_byte());
    end else if (kind < 24) begin
      buf_q.push_back(HDR_BYTE);
      buf_q.push_back(HDR_BYTE);
      buf_q.push_back(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(MAX_KEYS + 1, 255)));
      repeat ($urandom_range(0, 4)) buf_q.push_back(noise_byte());
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        buf_q.push_back(HDR_BYTE);
        buf_q.push_back(noise_byte());
      end
      repeat (($urandom_range(0, 3) == 0) ? 2 : 1)
        add_frame(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4),
                  $urandom_range(0, 9) == 0);
      if (kind < 32) begin
        cut   = $urandom_range(2, buf_q.size() - 2);
        buf_q = buf_q[0:cut];
      end else if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 3))
          buf_q.push_back(($urandom_range(0, 3) == 0) ? HDR_BYTE : noise_byte());
      end
    end
    if (kind >= 10)
      while (buf_q.size() < MIN_BUFFER) buf_q.push_front(noise_byte());
  endtask

  task automatic send_buffer();
    foreach (buf_q[i]) send_item(buf_q[i], i == buf_q.size() - 1, 1'b0, ST_KEY_EVENT);
  endtask

  task automatic run_random(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_buffer();
      send_buffer();
      sent += buf_q.size();
    end
  endtask

  task automatic drain_results();
    byte_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    // a zero-key frame gives no item, so let the block settle too
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_enable(input logic v);
    drain_results();
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    parser_on  = v;
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= 1'b0;
    byte_ch.valid      <= 1'b0;
    byte_ch.rx_byte    <= 8'h00;
    byte_ch.buffer_end <= 1'b0;
    reset_predictor();
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].rx_byte, directed_rows[i].buf_end,
                directed_rows[i].typed, directed_rows[i].typed_status);

    write_enable(1'b1);
    run_random(20);
    write_enable(1'b0);
    run_random(15);
    write_enable(1'b1);

    // full store while the receiver holds off; input keeps coming behind it
    long_hold_req = 1'b1;
    buf_q = {};
    add_frame(MAX_KEYS, 1'b0);
    send_buffer();
    run_random(15);

    drain_results();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : result_sink
    int n;
    forever begin
      n = draw_gap(rx_burst);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        n = HOLD;
      end
      if (n > 0) begin
        result_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    key_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch("result item with nothing expected, status", 32'(result_ch.status), 32'h0);
      end else begin
        want = expected_events.pop_front();
        if (result_ch.status !== want.status)
          report_mismatch("status", 32'(result_ch.status), 32'(want.status));
        if (result_ch.event_type !== want.ev_type)
          report_mismatch("event_type", 32'(result_ch.event_type), 32'(want.ev_type));
        if (result_ch.event_code !== want.ev_code)
          report_mismatch("event_code", 32'(result_ch.event_code), 32'(want.ev_code));
        if (result_ch.event_value !== want.ev_value)
          report_mismatch("event_value", result_ch.event_value, want.ev_value);
        if (result_ch.last_result !== want.last)
          report_mismatch("last_result", 32'(result_ch.last_result), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
